// File: rtl/core/limit_alarm_buzzer_controller_macros.svh
// Assertion helpers for the limit alarm buzzer controller.
// Every check is clocked on aclk and held off while aresetn is low.
`ifndef LIMIT_ALARM_BUZZER_CONTROLLER_MACROS_SVH
`define LIMIT_ALARM_BUZZER_CONTROLLER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define LABC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("labc check failed");

// Next-cycle implication.
`define LABC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("labc check failed");

`else

`define LABC_ASSERT_IMPL(label, ante, cons)
`define LABC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/labc_pkg.sv
`default_nettype none

package labc_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned PERIOD_W = 8;
    localparam int unsigned BEEP_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Register defaults
    localparam logic [TICK_W-1:0]   ON_TICKS_RST     = TICK_W'(750);
    localparam logic [TICK_W-1:0]   OFF_TICKS_RST    = TICK_W'(250);
    localparam logic [TICK_W-1:0]   BASE_TICKS_RST   = TICK_W'(900);
    localparam logic [PERIOD_W-1:0] MUTE_PERIODS_RST = PERIOD_W'(30);
    localparam logic [BEEP_W-1:0]   BEEP_LIMIT_RST   = BEEP_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ON_TICKS     = 3'd0,
        REG_OFF_TICKS    = 3'd1,
        REG_BASE_TICKS   = 3'd2,
        REG_MUTE_PERIODS = 3'd3,
        REG_BEEP_LIMIT   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0]   on_ticks;
        logic [TICK_W-1:0]   off_ticks;
        logic [TICK_W-1:0]   base_ticks;
        logic [PERIOD_W-1:0] mute_periods;
        logic [BEEP_W-1:0]   beep_limit;
    } cfg_t;

    typedef struct packed {
        logic                running;
        logic                muted;
        logic                pause;
        logic                continuous;
        logic                relay;
        logic [TICK_W-1:0]   base_count;
        logic [PERIOD_W-1:0] period_count;
        logic [TICK_W-1:0]   phase_count;
        logic [BEEP_W-1:0]   beep_count;
    } alarm_state_t;

    // Status handed from the core to the top level
    typedef struct packed {
        logic relay;
        logic running;
        logic muted;
        logic continuous;
    } alarm_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/limit_alarm_buzzer_controller.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_limit_active, s_mute_pressed (one 10 ms tick)
// m_       out  m_valid/m_ready    m_relay_on, m_alarm_active, m_alarm_muted,
//                                  m_ring_continuous
// cfg_     in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// One tick per clock: an s_ transfer updates the alarm state at that edge, and
// the state register is the result register on m_, valid from the next cycle.
// s_ready is high while m_ holds nothing or is being taken, so a stalled m_
// side holds the input off until the waiting result goes; otherwise 1/cycle.
// aresetn (synchronous, active low) clears all flags and counters and loads
// the register defaults: on 750, off 250, base 900, periods 30, limit 20.
`default_nettype none

`include "limit_alarm_buzzer_controller_macros.svh"

module limit_alarm_buzzer_controller
    import labc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // tick input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_limit_active,
    input  wire logic                  s_mute_pressed,

    // result output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_relay_on,
    output logic                       m_alarm_active,
    output logic                       m_alarm_muted,
    output logic                       m_ring_continuous,

    // register writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t         cfg;
    alarm_flags_t flags;
    logic         s_xfer;
    logic         m_valid_reg;
    logic         m_valid_next;

    // Accept whenever the result slot is empty or drains this cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    labc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // State register doubles as the result register.
    labc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_xfer),
        .limit_active (s_limit_active),
        .mute_pressed (s_mute_pressed),
        .cfg          (cfg),
        .flags        (flags)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_relay_on        = flags.relay;
    assign m_alarm_active    = flags.running;
    assign m_alarm_muted     = flags.muted;
    assign m_ring_continuous = flags.continuous;

    // Continuous ringing and mute only exist inside a running alarm.
    `LABC_ASSERT_IMPL(a_cont_needs_run, m_ring_continuous, m_alarm_active)
    `LABC_ASSERT_IMPL(a_mute_needs_run, m_alarm_muted, m_alarm_active)
    // A tick with the limit released clears the alarm and the relay.
    `LABC_ASSERT_NEXT(a_release_clears, s_xfer && !s_limit_active,
        !m_alarm_active && !m_relay_on && !m_alarm_muted)
    // A tick with the limit held always leaves the alarm running.
    `LABC_ASSERT_NEXT(a_limit_runs, s_xfer && s_limit_active, m_alarm_active && m_valid)
    // An empty result slot never blocks the input.
    `LABC_ASSERT_IMPL(a_ready_when_empty, !m_valid, s_ready)

endmodule

`default_nettype wire

// File: rtl/core/labc_cfg.sv
`default_nettype none

module labc_cfg
    import labc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ON_TICKS:     cfg_next.on_ticks     = cfg_wdata[TICK_W-1:0];
                REG_OFF_TICKS:    cfg_next.off_ticks    = cfg_wdata[TICK_W-1:0];
                REG_BASE_TICKS:   cfg_next.base_ticks   = cfg_wdata[TICK_W-1:0];
                REG_MUTE_PERIODS: cfg_next.mute_periods = cfg_wdata[PERIOD_W-1:0];
                REG_BEEP_LIMIT:   cfg_next.beep_limit   = cfg_wdata[BEEP_W-1:0];
                default:          cfg_next = cfg_reg; // unmapped index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_ticks     <= ON_TICKS_RST;
            cfg_reg.off_ticks    <= OFF_TICKS_RST;
            cfg_reg.base_ticks   <= BASE_TICKS_RST;
            cfg_reg.mute_periods <= MUTE_PERIODS_RST;
            cfg_reg.beep_limit   <= BEEP_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/labc_core.sv
`default_nettype none

module labc_core
    import labc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  wire logic limit_active,
    input  wire logic mute_pressed,
    input  wire cfg_t cfg,
    output alarm_flags_t flags
);

    alarm_state_t state_reg;
    alarm_state_t state_next;

    // One tick: limit edge or release, mute press, mute timeout, then beep pulsing.
    always_comb begin
        state_next = state_reg;

        // limit edge / release
        if (limit_active) begin
            if (!state_reg.running) begin
                state_next.running = 1'b1;
                state_next.relay   = 1'b1;
            end
        end else if (state_reg.running) begin
            state_next = '0;
        end

        // mute press only counts while running
        if (mute_pressed && state_next.running) begin
            state_next.muted        = 1'b1;
            state_next.period_count = '0;
            state_next.relay        = 1'b0;
        end

        // mute timeout
        if (state_next.muted) begin
            state_next.base_count = state_next.base_count + TICK_W'(1);
            if (state_next.base_count >= cfg.base_ticks) begin
                state_next.base_count   = '0;
                state_next.period_count = state_next.period_count + PERIOD_W'(1);
                if (state_next.period_count >= cfg.mute_periods) begin
                    state_next.period_count = '0;
                    state_next.muted        = 1'b0;
                end
            end
        end

        // beep pulsing; ring phase falls straight into the pause branch
        if (state_next.running && !state_next.muted && !state_next.continuous) begin
            if (!state_next.pause) begin
                state_next.phase_count = state_next.phase_count + TICK_W'(1);
                if (state_next.phase_count >= cfg.on_ticks) begin
                    state_next.relay       = 1'b0;
                    state_next.phase_count = '0;
                    state_next.pause       = 1'b1;
                end
            end
            if (state_next.pause) begin
                state_next.phase_count = state_next.phase_count + TICK_W'(1);
                if (state_next.phase_count >= cfg.off_ticks) begin
                    state_next.relay       = 1'b1;
                    state_next.phase_count = '0;
                    state_next.pause       = 1'b0;
                    state_next.beep_count  = state_next.beep_count + BEEP_W'(1);
                end
            end
            if (state_next.beep_count > cfg.beep_limit) begin
                state_next.relay      = 1'b1;
                state_next.continuous = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign flags.relay      = state_reg.relay;
    assign flags.running    = state_reg.running;
    assign flags.muted      = state_reg.muted;
    assign flags.continuous = state_reg.continuous;

endmodule

`default_nettype wire

// File: tb/limit_alarm_buzzer_controller_test.sv
`timescale 1ns / 100ps

module limit_alarm_buzzer_controller_test;
    import labc_pkg::*;

    localparam int  HALF_PERIOD = 6;      // 12 ns clock
    localparam int  RESET_CYCLES = 5;
    localparam int  LONG_HOLD = 60;       // receiver hold-off, in cycles
    localparam int  DRAIN_LIMIT = 5000;   // cycles allowed for the last results
    localparam int  TAIL_CYCLES = 4;      // a little margin after the drain loop

    // Receiver behavior for one stretch of cycles
    typedef enum int {
        RX_ALWAYS,   // take every result
        RX_COIN,     // take about half
        RX_MOSTLY    // take four out of five
    } rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_limit_active = 1'b0;
    logic                  s_mute_pressed = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_relay_on;
    logic                  m_alarm_active;
    logic                  m_alarm_muted;
    logic                  m_ring_continuous;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Alarm predictor: its own copy of the registers and of the alarm state.
    // Set up at time zero, then touched only by the sampling process below.
    cfg_t         alarm_regs;
    alarm_state_t alarm_now;

    // Flags each accepted tick should produce, oldest first
    alarm_flags_t pending_flags[$];

    int error_count = 0;
    int ticks_accepted = 0;
    int results_checked = 0;
    int settings_written = 0;

    // Sender burst bookkeeping
    int burst_left = 0;

    // Receiver pattern bookkeeping
    bit       hold_off_req = 1'b0;
    int       hold_left = 0;
    int       stretch_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    limit_alarm_buzzer_controller uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_limit_active    (s_limit_active),
        .s_mute_pressed    (s_mute_pressed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_relay_on        (m_relay_on),
        .m_alarm_active    (m_alarm_active),
        .m_alarm_muted     (m_alarm_muted),
        .m_ring_continuous (m_ring_continuous),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // One 10 ms tick of the alarm: advances the predicted state and returns
    // the flags as they stand after the tick.
    function automatic alarm_flags_t predict_tick(input logic limit, input logic mute);
        alarm_flags_t flags;
        // Limit edge starts the alarm; release wipes everything, relay included
        if (limit) begin
            if (!alarm_now.running) begin
                alarm_now.running = 1'b1;
                alarm_now.relay = 1'b1;
            end
        end else if (alarm_now.running) begin
            alarm_now = '0;
        end
        // Mute restarts the period count only, base_count keeps going
        if (mute && alarm_now.running) begin
            alarm_now.muted = 1'b1;
            alarm_now.period_count = '0;
            alarm_now.relay = 1'b0;
        end
        if (alarm_now.muted) begin
            alarm_now.base_count = alarm_now.base_count + TICK_W'(1);
            if (alarm_now.base_count >= alarm_regs.base_ticks) begin
                alarm_now.base_count = '0;
                alarm_now.period_count = alarm_now.period_count + PERIOD_W'(1);
                if (alarm_now.period_count >= alarm_regs.mute_periods) begin
                    alarm_now.period_count = '0;
                    alarm_now.muted = 1'b0;
                end
            end
        end
        // Pulse logic. Entering the pause counts once more in the same tick,
        // so the pause is one tick short.
        if (alarm_now.running && !alarm_now.muted && !alarm_now.continuous) begin
            if (!alarm_now.pause) begin
                alarm_now.phase_count = alarm_now.phase_count + TICK_W'(1);
                if (alarm_now.phase_count >= alarm_regs.on_ticks) begin
                    alarm_now.relay = 1'b0;
                    alarm_now.phase_count = '0;
                    alarm_now.pause = 1'b1;
                end
            end
            if (alarm_now.pause) begin
                alarm_now.phase_count = alarm_now.phase_count + TICK_W'(1);
                if (alarm_now.phase_count >= alarm_regs.off_ticks) begin
                    alarm_now.relay = 1'b1;
                    alarm_now.phase_count = '0;
                    alarm_now.pause = 1'b0;
                    alarm_now.beep_count = alarm_now.beep_count + BEEP_W'(1);
                end
            end
            if (alarm_now.beep_count > alarm_regs.beep_limit) begin
                alarm_now.relay = 1'b1;
                alarm_now.continuous = 1'b1;
            end
        end
        flags.relay = alarm_now.relay;
        flags.running = alarm_now.running;
        flags.muted = alarm_now.muted;
        flags.continuous = alarm_now.continuous;
        return flags;
    endfunction

    // Everything is sampled at the rising edge, before the block's registers
    // move. Result first, so the queue front is always an older tick.
    always @(posedge aclk) begin : sample_edge
        alarm_flags_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_flags.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    error_count++;
                end else begin
                    want = pending_flags.pop_front();
                    results_checked++;
                    if (m_relay_on !== want.relay) begin
                        $error("relay_on: expected %0b, got %0b", want.relay, m_relay_on);
                        error_count++;
                    end
                    if (m_alarm_active !== want.running) begin
                        $error("alarm_active: expected %0b, got %0b",
                               want.running, m_alarm_active);
                        error_count++;
                    end
                    if (m_alarm_muted !== want.muted) begin
                        $error("alarm_muted: expected %0b, got %0b", want.muted, m_alarm_muted);
                        error_count++;
                    end
                    if (m_ring_continuous !== want.continuous) begin
                        $error("ring_continuous: expected %0b, got %0b",
                               want.continuous, m_ring_continuous);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_flags.push_back(predict_tick(s_limit_active, s_mute_pressed));
                ticks_accepted++;
            end
            // Register writes only happen while idle, so order here is moot.
            // Indexes past the last register are dropped.
            if (cfg_we) begin
                case (cfg_index)
                    REG_ON_TICKS:     alarm_regs.on_ticks = cfg_wdata[TICK_W-1:0];
                    REG_OFF_TICKS:    alarm_regs.off_ticks = cfg_wdata[TICK_W-1:0];
                    REG_BASE_TICKS:   alarm_regs.base_ticks = cfg_wdata[TICK_W-1:0];
                    REG_MUTE_PERIODS: alarm_regs.mute_periods = cfg_wdata[PERIOD_W-1:0];
                    REG_BEEP_LIMIT:   alarm_regs.beep_limit = cfg_wdata[BEEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver: random stretches of always-ready, coin-flip and mostly-ready,
    // plus a long hold-off on request, counted here.
    always @(negedge aclk) begin
        if (hold_off_req) begin
            hold_left = LONG_HOLD;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(int'(RX_ALWAYS), int'(RX_MOSTLY)));
                stretch_left = $urandom_range(8, 64);
            end
            stretch_left--;
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
                default:   m_ready <= 1'b1;
            endcase
        end
    end

    // Offer one tick and hold it until the transfer. Between bursts of random
    // length the sender drops valid for a random gap.
    task automatic send_tick(input logic limit, input logic mute);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_limit_active <= limit;
        s_mute_pressed <= mute;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Sender goes quiet until every outstanding result has been taken
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Write all five registers; the narrow ones get junk in the upper byte,
    // which the block must drop.
    task automatic program_regs(input logic [TICK_W-1:0] on_t, input logic [TICK_W-1:0] off_t,
                                input logic [TICK_W-1:0] base_t,
                                input logic [PERIOD_W-1:0] periods,
                                input logic [BEEP_W-1:0] limit);
        write_reg(REG_ON_TICKS, on_t);
        write_reg(REG_OFF_TICKS, off_t);
        write_reg(REG_BASE_TICKS, base_t);
        write_reg(REG_MUTE_PERIODS, {8'($urandom), periods});
        write_reg(REG_BEEP_LIMIT, {8'($urandom), limit});
        settings_written++;
    endtask

    function automatic logic mute_roll(input int odds);
        return (odds != 0) && ($urandom_range(1, odds) == 1);
    endfunction

    // Mostly whole alarm episodes (trigger, hold with the odd mute press,
    // release), the rest random noise ticks.
    task automatic run_episodes(input int count, input int min_hold, input int max_hold,
                                input int mute_odds);
        int sent;
        int hold;
        int n;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                send_tick(1'b1, mute_roll(mute_odds));
                hold = $urandom_range(min_hold, max_hold);
                repeat (hold) send_tick(1'b1, mute_roll(mute_odds));
                n = $urandom_range(1, 3);
                repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
                sent += 1 + hold + n;
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent += n;
            end
        end
    endtask

    // Register defaults straight out of reset: trigger, mute, release
    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);      // mute with no alarm does nothing
        send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_idle();
    endtask

    // Short pulses so a handful of ticks reach the one-tick pause, the
    // continuous latch, mute expiry while latched, and mute on the trigger tick
    task automatic test_directed_cases();
        program_regs(16'd2, 16'd1, 16'd2, 8'd2, 8'd1);
        for (int i = int'(REG_BEEP_LIMIT) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), 16'hFFFF);
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b1, 1'b0);   // two beeps, then continuous
        send_tick(1'b1, 1'b1);
        repeat (4) send_tick(1'b1, 1'b0);   // mute runs out, relay stays off
        send_tick(1'b0, 1'b1);              // release with mute held
        send_tick(1'b1, 1'b1);              // trigger and mute together
        repeat (2) send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);              // second press mid-mute
        repeat (3) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        wait_idle();
    endtask

    // Random episodes under a range of register settings, extremes included
    task automatic test_register_settings();
        repeat (3) begin
            program_regs(TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)),
                         TICK_W'($urandom_range(1, 4)), PERIOD_W'($urandom_range(1, 3)),
                         BEEP_W'($urandom_range(0, 4)));
            run_episodes(45, 1, 24, 8);
            wait_idle();
        end
        program_regs(TICK_W'($urandom_range(3, 40)), TICK_W'($urandom_range(3, 40)),
                     TICK_W'($urandom_range(5, 20)), PERIOD_W'($urandom_range(1, 4)),
                     BEEP_W'($urandom_range(0, 3)));
        run_episodes(60, 20, 120, 30);
        wait_idle();
        // All zero: every >= compare against a limit holds at once, and the first beep passes the beep limit
        program_regs('0, '0, '0, '0, '0);
        run_episodes(50, 1, 12, 5);
        wait_idle();
        // One beep per tick and the highest beep limit that can still trip: continuous after 255 beeps
        program_regs(16'd1, 16'd1, 16'd2, 8'd2, 8'd254);
        run_episodes(240, 260, 290, 0);
        wait_idle();
        // All ones: nothing times out within the run
        program_regs('1, '1, '1, '1, '1);
        run_episodes(30, 4, 12, 6);
        wait_idle();
    endtask

    // Receiver holds off long enough for the block to fill and stall its
    // input while the sender keeps offering ticks; then a full pause.
    task automatic test_output_backpressure();
        program_regs(16'd3, 16'd2, 16'd2, 8'd2, 8'd2);
        hold_off_req = 1'b1;
        run_episodes(16, 4, 10, 4);
        wait_idle();
        run_episodes(8, 2, 6, 4);
        wait_idle();
    endtask

    initial begin
        alarm_regs.on_ticks = ON_TICKS_RST;
        alarm_regs.off_ticks = OFF_TICKS_RST;
        alarm_regs.base_ticks = BASE_TICKS_RST;
        alarm_regs.mute_periods = MUTE_PERIODS_RST;
        alarm_regs.beep_limit = BEEP_LIMIT_RST;
        alarm_now = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_register_settings();
        test_output_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_flags.size() != 0; w++)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_flags.size() != 0) begin
            $error("%0d ticks never produced a result", pending_flags.size());
            error_count++;
        end

        $display("Checked %0d results against %0d accepted ticks over %0d register settings",
                 results_checked, ticks_accepted, settings_written);
        $display("Settings spanned zero, small, one-tick and all-ones limits plus a long stall");
        if (error_count == 0)
            $display("PASS limit_alarm_buzzer_controller");
        else
            $display("FAIL limit_alarm_buzzer_controller");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #3000000;
        $display("FAIL limit_alarm_buzzer_controller");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/labc_pkg.sv
rtl/core/labc_cfg.sv
rtl/core/labc_core.sv
rtl/core/limit_alarm_buzzer_controller.sv
tb/limit_alarm_buzzer_controller_test.sv
